FILE: src/swsfd_pkg.sv
// Shared types and constants for the single-wire sensor frame decoder.
`default_nettype none

package swsfd_pkg;

   localparam int FRAME_BITS  = 40;
   localparam int BIT_COUNT_W = 6;
   localparam int WORD_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WORD_W-1:0] RESPONSE_MIN_RESET  = 16'd400;
   localparam logic [WORD_W-1:0] BIT_THRESHOLD_RESET = 16'd276;

   typedef enum logic [1:0] {
      MODE_START    = 2'd0,
      MODE_EDGE     = 2'd1,
      MODE_OVERFLOW = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_RESPONSE = 2'd1,
      STATUS_SHORT       = 2'd2,
      STATUS_CHECKSUM    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RESPONSE_MIN  = 1'b0,
      CSR_BIT_THRESHOLD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [WORD_W-1:0] interval;
   } item_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [WORD_W-1:0] humidity;
      logic [WORD_W-1:0] temperature;
   } result_type;

   typedef struct packed {
      logic [WORD_W-1:0] response_min;
      logic [WORD_W-1:0] bit_threshold;
   } cfg_type;

endpackage

`default_nettype wire

FILE: src/swsfd_req_if.sv
// Request channel carrying start, edge interval and overflow items.
`default_nettype none

interface swsfd_req_if import swsfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [WORD_W-1:0] interval;

   modport source (output valid, mode, interval, input ready);
   modport sink   (input valid, mode, interval, output ready);
endinterface

`default_nettype wire

FILE: src/swsfd_rsp_if.sv
// Response channel carrying decoded read results.
`default_nettype none

interface swsfd_rsp_if import swsfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [WORD_W-1:0] humidity;
   logic [WORD_W-1:0] temperature;

   modport source (output valid, status, humidity, temperature, input ready);
   modport sink   (input valid, status, humidity, temperature, output ready);
endinterface

`default_nettype wire

FILE: src/swsfd_core.sv
// Read sequencer: phase, bit counter, frame shift register and checksum.
`default_nettype none

module swsfd_core import swsfd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output logic            res_valid,
   output result_type      res
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_RESPONSE = 2'd1,
      PH_DATA     = 2'd2
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [BIT_COUNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [FRAME_BITS-1:0]   frame_shift_ff, frame_shift_in;
   logic                    data_bit;
   logic [FRAME_BITS-1:0]   shifted;
   logic [BIT_COUNT_W-1:0]  count_inc;
   logic [BYTE_W-1:0]       byte_sum;

   assign data_bit  = (item.interval > cfg.bit_threshold);
   assign shifted   = {frame_shift_ff[FRAME_BITS-2:0], data_bit};
   assign count_inc = bit_count_ff + BIT_COUNT_W'(1);
   // The checksum covers the frame as it stands after this bit is shifted in.
   assign byte_sum  = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];

   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      frame_shift_in = frame_shift_ff;
      res_valid      = 1'b0;
      res            = '0;
      if (item_valid) begin
         unique case (item.mode)
            MODE_START: begin
               phase_in       = PH_RESPONSE;
               bit_count_in   = '0;
               frame_shift_in = '0;
            end
            MODE_EDGE, MODE_OVERFLOW: begin
               if (phase_ff == PH_RESPONSE) begin
                  if (item.mode == MODE_OVERFLOW) begin
                     phase_in   = PH_IDLE;
                     res_valid  = 1'b1;
                     res.status = STATUS_NO_RESPONSE;
                  end else if (item.interval < cfg.response_min) begin
                     phase_in   = PH_IDLE;
                     res_valid  = 1'b1;
                     res.status = STATUS_SHORT;
                  end else begin
                     phase_in       = PH_DATA;
                     bit_count_in   = '0;
                     frame_shift_in = '0;
                  end
               end else if (phase_ff == PH_DATA && item.mode == MODE_EDGE) begin
                  frame_shift_in = shifted;
                  bit_count_in   = count_inc;
                  if (count_inc >= BIT_COUNT_W'(FRAME_BITS)) begin
                     phase_in     = PH_IDLE;
                     bit_count_in = '0;
                     res_valid    = 1'b1;
                     if (byte_sum != shifted[7:0]) begin
                        res.status = STATUS_CHECKSUM;
                     end else begin
                        res.status      = STATUS_OK;
                        res.humidity    = shifted[39:24];
                        res.temperature = shifted[23:8];
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         frame_shift_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         frame_shift_ff <= frame_shift_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/single_wire_sensor_frame_decoder_unit.sv
// Top level: input register, control registers, read sequencer and result register.
//
// The decoder takes one item per clock cycle while ready is high. An accepted item
// is held in an input register and goes through the read sequencer once the result
// register is free or being emptied. Any result it causes is written into the result
// register and from there offered on the response channel. The request side stays
// ready while a result waits, and drops ready only when both the input register and
// the result register are full and the response side is stalled.
// Control registers are written through csr_we, csr_index and csr_wdata.
`default_nettype none

module single_wire_sensor_frame_decoder_unit import swsfd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   swsfd_req_if.sink                   req_chan,
   swsfd_rsp_if.source                 rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   item_type    in_item_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   cfg_type     cfg_ff, cfg_in;
   logic        advance;
   logic        req_take;
   logic        core_valid;
   result_type  core_res;

   // The held item moves on when the result register is free or being emptied.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? core_valid : (out_valid_ff && !rsp_chan.ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RESPONSE_MIN:  cfg_in.response_min  = csr_wdata;
            CSR_BIT_THRESHOLD: cfg_in.bit_threshold = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   swsfd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_item_ff),
      .cfg        (cfg_ff),
      .res_valid  (core_valid),
      .res        (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         cfg_ff.response_min  <= RESPONSE_MIN_RESET;
         cfg_ff.bit_threshold <= BIT_THRESHOLD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
      if (req_take) begin
         in_item_ff.mode     <= req_chan.mode;
         in_item_ff.interval <= req_chan.interval;
      end
      if (advance && core_valid) begin
         out_ff <= core_res;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.humidity    = out_ff.humidity;
   assign rsp_chan.temperature = out_ff.temperature;

   // Back-pressure reaches the request side only when both registers are occupied.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_valid_ff && out_valid_ff && !rsp_chan.ready))
      else $error("request side stalled with room in the pipeline");

   // A new result can only come from an item leaving the input register.
   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("result appeared without an item being processed");

   // The held item is only dropped after it was processed.
   a_item_not_lost: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held item lost before processing");

endmodule

`default_nettype wire

FILE: tb/swsfd_frame_checker.sv
// Checker that predicts decoded sensor reads from observed transfers and compares results.
`timescale 1ns / 100ps

module swsfd_frame_checker import swsfd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   swsfd_req_if                        req_chan,
   swsfd_rsp_if                        rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          fail_count,
   output int                          pending_count,
   output int                          checked_count
);

   typedef enum logic [1:0] {
      READ_IDLE     = 2'd0,
      READ_RESPONSE = 2'd1,
      READ_DATA     = 2'd2
   } read_phase_type;

   read_phase_type           read_phase;
   logic [BIT_COUNT_W-1:0]   bits_seen;
   logic [FRAME_BITS-1:0]    frame_bits;
   cfg_type                  decode_cfg;
   result_type               expected_reads[$];
   result_type               got;
   result_type               want;

   function automatic result_type failed_read(input status_type st);
      result_type r;
      r.status      = st;
      r.humidity    = '0;
      r.temperature = '0;
      return r;
   endfunction

   // Advances the read state by one accepted item and queues any result it causes.
   function automatic void decode_item(input item_type it);
      logic [BYTE_W-1:0] byte_sum;
      result_type        r;
      case (it.mode)
         MODE_START: begin
            read_phase = READ_RESPONSE;
            bits_seen  = '0;
            frame_bits = '0;
         end
         MODE_EDGE, MODE_OVERFLOW: begin
            if (read_phase == READ_RESPONSE) begin
               if (it.mode == MODE_OVERFLOW) begin
                  read_phase = READ_IDLE;
                  expected_reads.push_back(failed_read(STATUS_NO_RESPONSE));
               end else if (it.interval < decode_cfg.response_min) begin
                  read_phase = READ_IDLE;
                  expected_reads.push_back(failed_read(STATUS_SHORT));
               end else begin
                  read_phase = READ_DATA;
                  bits_seen  = '0;
                  frame_bits = '0;
               end
            end else if (read_phase == READ_DATA && it.mode == MODE_EDGE) begin
               frame_bits = {frame_bits[FRAME_BITS-2:0],
                             it.interval > decode_cfg.bit_threshold};
               bits_seen  = bits_seen + 1'b1;
               if (bits_seen >= FRAME_BITS) begin
                  read_phase = READ_IDLE;
                  bits_seen  = '0;
                  byte_sum   = frame_bits[39:32] + frame_bits[31:24] +
                               frame_bits[23:16] + frame_bits[15:8];
                  if (byte_sum != frame_bits[7:0]) begin
                     expected_reads.push_back(failed_read(STATUS_CHECKSUM));
                  end else begin
                     r.status      = STATUS_OK;
                     r.humidity    = frame_bits[39:24];
                     r.temperature = frame_bits[23:8];
                     expected_reads.push_back(r);
                  end
               end
            end
         end
         default: begin
            // The unused mode leaves the read untouched.
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         read_phase               = READ_IDLE;
         bits_seen                = '0;
         frame_bits               = '0;
         decode_cfg.response_min  = RESPONSE_MIN_RESET;
         decode_cfg.bit_threshold = BIT_THRESHOLD_RESET;
         expected_reads.delete();
         fail_count               = 0;
         pending_count            = 0;
         checked_count            = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RESPONSE_MIN:  decode_cfg.response_min  = csr_wdata;
               CSR_BIT_THRESHOLD: decode_cfg.bit_threshold = csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status      = rsp_chan.status;
            got.humidity    = rsp_chan.humidity;
            got.temperature = rsp_chan.temperature;
            if (expected_reads.size() == 0) begin
               $error("result with no read pending: status %0d humidity %h temperature %h",
                      got.status, got.humidity, got.temperature);
               fail_count++;
            end else begin
               want = expected_reads.pop_front();
               checked_count++;
               if (got.status != want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.humidity != want.humidity) begin
                  $error("humidity: expected %h, actual %h", want.humidity, got.humidity);
                  fail_count++;
               end
               if (got.temperature != want.temperature) begin
                  $error("temperature: expected %h, actual %h",
                         want.temperature, got.temperature);
                  fail_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            decode_item('{mode: req_chan.mode, interval: req_chan.interval});
         end
         pending_count = expected_reads.size();
      end
   end

endmodule

FILE: tb/single_wire_sensor_frame_decoder_unit_tb.sv
// Testbench top: clock, reset, read stimulus, register settings and the final verdict.
`timescale 1ns / 100ps

module single_wire_sensor_frame_decoder_unit_tb;
   import swsfd_pkg::*;

   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam int         ITEM_TARGET  = 1950;
   localparam int         READS_PER_CFG = 6;
   localparam int         HOLD_CYCLES  = 300;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int                     fail_count;
   int                     pending;
   int                     checked;
   int                     src_idle_pct;
   int                     sink_stall_pct;
   bit                     hold_request;
   int                     items_sent;
   int                     reads_sent;
   int                     settings_used;
   logic [WORD_W-1:0]      cur_rm;
   logic [WORD_W-1:0]      cur_bt;

   swsfd_req_if req_if();
   swsfd_rsp_if rsp_if();

   single_wire_sensor_frame_decoder_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   swsfd_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_if),
      .rsp_chan      (rsp_if),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending),
      .checked_count (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Offers one item and returns at the edge of its transfer; valid stays high after it.
   task automatic send_item(input logic [1:0] m, input logic [WORD_W-1:0] iv,
                            input bit counted);
      if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_if.valid    <= 1'b1;
      req_if.mode     <= m;
      req_if.interval <= iv;
      do @(posedge clock); while (!req_if.ready);
      if (counted) items_sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // An item with no result may still sit in the pipeline.
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic [WORD_W-1:0] rm, input logic [WORD_W-1:0] bt);
      csr_we    <= 1'b1;
      csr_index <= CSR_RESPONSE_MIN;
      csr_wdata <= rm;
      @(posedge clock);
      csr_index <= CSR_BIT_THRESHOLD;
      csr_wdata <= bt;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_rm = rm;
      cur_bt = bt;
      settings_used++;
   endtask

   function automatic logic [WORD_W-1:0] pick_word(input logic [WORD_W-1:0] nominal);
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return nominal;
         default: return WORD_W'($urandom());
      endcase
   endfunction

   // Interval that decodes as the given bit, often right at the threshold.
   function automatic logic [WORD_W-1:0] bit_interval(input logic one);
      if (one) begin
         if (cur_bt == '1) return '1;
         if ($urandom_range(1)) return cur_bt + 1'b1;
         return WORD_W'($urandom_range(65535, 32'(cur_bt) + 1));
      end
      if ($urandom_range(1)) return cur_bt;
      return WORD_W'($urandom_range(32'(cur_bt), 0));
   endfunction

   function automatic logic [WORD_W-1:0] response_interval();
      return WORD_W'($urandom_range(65535, 32'(cur_rm)));
   endfunction

   task automatic send_frame();
      logic [31:0]           data;
      logic [BYTE_W-1:0]     chk;
      logic [FRAME_BITS-1:0] frame;
      case ($urandom_range(9))
         0:       data = '0;
         1:       data = '1;
         default: data = $urandom();
      endcase
      chk = data[31:24] + data[23:16] + data[15:8] + data[7:0];
      if ($urandom_range(4) == 0) chk = chk ^ BYTE_W'($urandom_range(255, 1));
      frame = {data, chk};
      send_item(MODE_START, WORD_W'($urandom()), 1'b1);
      send_item(MODE_EDGE, response_interval(), 1'b1);
      for (int i = FRAME_BITS - 1; i >= 0; i--) begin
         // Now and then an overflow or unused item lands mid-frame and must be ignored.
         if ($urandom_range(49) == 0)
            send_item($urandom_range(1) ? MODE_OVERFLOW : MODE_UNUSED,
                      WORD_W'($urandom()), 1'b0);
         send_item(MODE_EDGE, bit_interval(frame[i]), 1'b1);
      end
      reads_sent++;
   endtask

   task automatic send_broken_read();
      int kept;
      send_item(MODE_START, WORD_W'($urandom()), 1'b1);
      case ($urandom_range(3))
         0: send_item(MODE_OVERFLOW, WORD_W'($urandom()), 1'b1);
         1: begin
            if (cur_rm == '0)
               send_item(MODE_EDGE, '0, 1'b1);
            else if ($urandom_range(1))
               send_item(MODE_EDGE, cur_rm - 1'b1, 1'b1);
            else
               send_item(MODE_EDGE, WORD_W'($urandom_range(32'(cur_rm) - 1, 0)), 1'b1);
         end
         2: begin
            // The frame is abandoned part way; the next start drops it.
            send_item(MODE_EDGE, response_interval(), 1'b1);
            kept = $urandom_range(FRAME_BITS - 1, 0);
            repeat (kept) send_item(MODE_EDGE, WORD_W'($urandom()), 1'b1);
         end
         default: begin
            repeat ($urandom_range(3, 1))
               send_item(2'($urandom_range(3)), WORD_W'($urandom()), 1'b1);
         end
      endcase
      reads_sent++;
   endtask

   initial begin
      int block;
      int reads_in_block;
      int profile;
      req_if.valid    = 1'b0;
      req_if.mode     = MODE_START;
      req_if.interval = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_RESPONSE_MIN;
      csr_wdata       = '0;
      reset           = 1'b1;
      src_idle_pct    = 0;
      sink_stall_pct  = 0;
      hold_request    = 1'b0;
      items_sent      = 0;
      reads_sent      = 0;
      settings_used   = 0;
      cur_rm          = RESPONSE_MIN_RESET;
      cur_bt          = BIT_THRESHOLD_RESET;
      block           = 0;
      reads_in_block  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases under the reset register values.
      send_item(MODE_EDGE, 16'hFFFF, 1'b0);      // edge while idle
      send_item(MODE_OVERFLOW, 16'h0000, 1'b0);  // overflow while idle
      send_item(MODE_UNUSED, 16'hFFFF, 1'b0);    // unused mode while idle
      send_item(MODE_START, 16'h0000, 1'b1);
      send_item(MODE_OVERFLOW, 16'hFFFF, 1'b1);  // no response
      send_item(MODE_START, 16'hFFFF, 1'b1);
      send_item(MODE_EDGE, RESPONSE_MIN_RESET - 1'b1, 1'b1);  // just too short
      send_item(MODE_START, 16'h5555, 1'b1);
      send_item(MODE_EDGE, 16'h0000, 1'b1);
      send_item(MODE_START, 16'hAAAA, 1'b1);
      send_item(MODE_EDGE, RESPONSE_MIN_RESET, 1'b1);  // shortest valid response
      send_item(MODE_EDGE, BIT_THRESHOLD_RESET + 1'b1, 1'b1);
      send_item(MODE_EDGE, BIT_THRESHOLD_RESET, 1'b1);
      send_item(MODE_OVERFLOW, 16'h1234, 1'b0);  // overflow during data is ignored
      send_item(MODE_UNUSED, 16'h0000, 1'b0);    // unused mode during data is ignored
      send_item(MODE_START, 16'hFFFF, 1'b1);     // restart while busy
      send_item(MODE_OVERFLOW, 16'h0000, 1'b1);
      send_item(MODE_START, 16'h0000, 1'b1);
      send_item(MODE_EDGE, 16'hFFFF, 1'b1);
      send_item(MODE_START, 16'h0000, 1'b1);     // restart from the data phase
      send_item(MODE_EDGE, 16'h0001, 1'b1);

      // Long receiver hold-off while the sender keeps offering failing reads.
      hold_request = 1'b1;
      repeat (16) begin
         send_item(MODE_START, WORD_W'($urandom()), 1'b1);
         send_item(MODE_OVERFLOW, WORD_W'($urandom()), 1'b1);
      end
      drain_results();

      while (items_sent < ITEM_TARGET) begin
         profile = items_sent * 4 / ITEM_TARGET;
         case (profile)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 79; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 79; end
            default: begin src_idle_pct = 14; sink_stall_pct = 14; end
         endcase
         if (reads_in_block == 0) begin
            drain_results();
            case (block % 5)
               0:       write_config(RESPONSE_MIN_RESET, BIT_THRESHOLD_RESET);
               1:       write_config('0, '0);
               2:       write_config('1, '1);
               default: write_config(pick_word(RESPONSE_MIN_RESET),
                                     pick_word(BIT_THRESHOLD_RESET));
            endcase
            block++;
         end
         if ($urandom_range(19) == 0)
            send_item($urandom_range(1) ? MODE_EDGE : MODE_OVERFLOW,
                      WORD_W'($urandom()), 1'b0);
         if ($urandom_range(9) < 7)
            send_frame();
         else
            send_broken_read();
         reads_in_block = (reads_in_block + 1) % READS_PER_CFG;
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d items in %0d reads over %0d register settings and four idle profiles.",
               items_sent, reads_sent, settings_used);
      $display("Checked %0d decoded results, %0d mismatches.", checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
